>>> rtl/chebyshev_waveshaper_macros.svh
// Assertion macros shared by the waveshaper RTL.
// Expect clk_i and rst_ni in the scope of use.
`ifndef CHEBYSHEV_WAVESHAPER_MACROS_SVH
`define CHEBYSHEV_WAVESHAPER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CWSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cwsh assertion failed");

// Same-cycle implication.
`define CWSH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cwsh assertion failed");

// Next-cycle implication.
`define CWSH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cwsh assertion failed");

`endif

>>> rtl/cwsh_pkg.sv
// Package for the Chebyshev waveshaper: widths, fixed-point constants and
// the pipeline stage payload types. No dependencies.
`timescale 1ns / 1ps

package cwsh_pkg;

  localparam int MAX_ORDER = 16;
  // one recurrence step per order above one
  localparam int STEPS     = MAX_ORDER - 1;
  localparam int ORD_W     = $clog2(MAX_ORDER + 1);
  localparam int CFG_W     = 5;
  localparam int X_W       = 16;
  // terms are Q.30 and clamp to [-4.0, 4.0]
  localparam int TERM_W    = 34;
  localparam int PROD_W    = X_W + TERM_W;
  localparam int TW_W      = PROD_W - 14;
  localparam int DIFF_W    = TW_W + 1;

  localparam logic signed [TERM_W-1:0] Q30_ONE     = TERM_W'(64'sd1 <<< 30);
  localparam logic signed [TERM_W-1:0] TERM_LIMIT  = TERM_W'(64'sd1 <<< 32);
  // smallest term that rounds to full scale or above
  localparam logic signed [TERM_W-1:0] SAT_HI_TERM =
    TERM_W'((64'sd1 <<< 30) - (64'sd1 <<< 15) - (64'sd1 <<< 14));
  localparam logic signed [X_W-1:0]    OUT_MAX     = 16'sh7fff;
  localparam logic signed [X_W-1:0]    OUT_MIN     = 16'sh8000;

  localparam logic [CFG_W-1:0] ORDER_RESET = CFG_W'(1);

  typedef struct packed {
    logic                     valid;
    logic [ORD_W-1:0]         rem;   // recurrence steps still to do
    logic signed [X_W-1:0]    x;
    logic signed [TERM_W-1:0] prev;
    logic signed [TERM_W-1:0] cur;
  } cwsh_term_t;

  typedef struct packed {
    logic                     valid;
    logic [ORD_W-1:0]         rem;
    logic signed [TERM_W-1:0] prev;
    logic signed [TERM_W-1:0] cur;
    logic signed [PROD_W-1:0] prod;  // x * cur, Q.45
    logic signed [X_W-1:0]    x;
  } cwsh_prod_t;

endpackage

>>> rtl/chebyshev_waveshaper.sv
// Top level of the Chebyshev waveshaper: order register, entry stage,
// recurrence pipeline and output stage. Depends on cwsh_pkg and the stage modules.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | in_valid_i / in_stall_o | sample_i (s16, Q1.15)
//  out     | output    | out_valid_o/out_stall_i | shaped_sample_o (s16)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_poly_order_i (u5)
//
// One sample per cycle enters while the output is not stalled; the latency is
// the same whatever the order: each recurrence step is a multiply stage and a
// subtract/clamp stage, and items with fewer steps pass through the rest.
// Reset sets the order to 1 and clears all valid bits.
// A stall on a valid output freezes the whole pipeline in the same cycle; in_stall_o
// follows it, so no transaction is lost or repeated.
`timescale 1ns / 1ps

module chebyshev_waveshaper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [cwsh_pkg::X_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [cwsh_pkg::X_W-1:0] shaped_sample_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cwsh_pkg::CFG_W-1:0] cfg_poly_order_i
);
  import cwsh_pkg::*;

  logic [CFG_W-1:0] order_q;
  logic [ORD_W-1:0] n_cap;
  logic             adv;
  cwsh_term_t       entry_d, entry_q;
  cwsh_term_t       term_s [STEPS+1];
  cwsh_prod_t       prod_s [STEPS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_valid_i) begin
      order_q <= cfg_poly_order_i;
    end
  end

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    if (32'(order_q) > 32'(MAX_ORDER)) begin
      n_cap = ORD_W'(MAX_ORDER);
    end else begin
      n_cap = ORD_W'(order_q);
    end

    entry_d.valid = in_valid_i;
    entry_d.x     = sample_i;
    entry_d.prev  = Q30_ONE;
    if (n_cap == '0) begin
      // order zero: T_0 = 1.0, no steps
      entry_d.rem = '0;
      entry_d.cur = Q30_ONE;
    end else begin
      entry_d.rem = n_cap - ORD_W'(1);
      entry_d.cur = TERM_W'(sample_i) <<< 15;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (adv) begin
      entry_q <= entry_d;
    end
  end

  assign term_s[0] = entry_q;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    cwsh_mul_stage u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .term_i (term_s[g]),
      .prod_o (prod_s[g])
    );

    cwsh_rec_stage u_rec (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .prod_i (prod_s[g]),
      .term_o (term_s[g+1])
    );
  end

  cwsh_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .term_i          (term_s[STEPS]),
    .out_valid_o     (out_valid_o),
    .shaped_sample_o (shaped_sample_o)
  );

endmodule

>>> rtl/cwsh_mul_stage.sv
// First half of one recurrence step: registers x * T_k.
// Depends on cwsh_pkg.
`timescale 1ns / 1ps

module cwsh_mul_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cwsh_pkg::cwsh_term_t term_i,
  output cwsh_pkg::cwsh_prod_t prod_o
);
  import cwsh_pkg::*;

  cwsh_prod_t prod_d, prod_q;

  always_comb begin
    prod_d.valid = term_i.valid;
    prod_d.rem   = term_i.rem;
    prod_d.x     = term_i.x;
    prod_d.prev  = term_i.prev;
    prod_d.cur   = term_i.cur;
    prod_d.prod  = PROD_W'($signed(term_i.x)) * PROD_W'($signed(term_i.cur));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/cwsh_rec_stage.sv
// Second half of one recurrence step: round 2*x*T_k, subtract T_(k-1),
// clamp. Items with no steps left pass unchanged. Depends on cwsh_pkg.
`timescale 1ns / 1ps
`include "chebyshev_waveshaper_macros.svh"

module cwsh_rec_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cwsh_pkg::cwsh_prod_t prod_i,
  output cwsh_pkg::cwsh_term_t term_o
);
  import cwsh_pkg::*;

  cwsh_term_t               term_d, term_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [TW_W-1:0]   twice;
  logic signed [DIFF_W-1:0] diff;
  logic signed [TERM_W-1:0] next;

  always_comb begin
    // floor((p + 2^13) / 2^14)
    rnd   = $signed(prod_i.prod) + PROD_W'(64'sd8192);
    twice = rnd[PROD_W-1:14];
    diff  = DIFF_W'(twice) - DIFF_W'($signed(prod_i.prev));
    if (diff > DIFF_W'(TERM_LIMIT)) begin
      next = TERM_LIMIT;
    end else if (diff < -DIFF_W'(TERM_LIMIT)) begin
      next = -TERM_LIMIT;
    end else begin
      next = diff[TERM_W-1:0];
    end

    term_d.valid = prod_i.valid;
    term_d.x     = prod_i.x;
    if (prod_i.rem != '0) begin
      term_d.rem  = prod_i.rem - ORD_W'(1);
      term_d.prev = prod_i.cur;
      term_d.cur  = next;
    end else begin
      term_d.rem  = prod_i.rem;
      term_d.prev = prod_i.prev;
      term_d.cur  = prod_i.cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
    end else if (en_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

  `CWSH_ASSERT_IMPL(a_term_range, term_q.valid && term_q.rem != $past(term_q.rem),
                    $signed(term_q.cur) <= TERM_LIMIT && $signed(term_q.cur) >= -TERM_LIMIT)
  `CWSH_ASSERT_NEXT(a_rem_dec, en_i && prod_i.valid && prod_i.rem != '0,
                    term_q.rem == $past(prod_i.rem) - ORD_W'(1))
  `CWSH_ASSERT_NEXT(a_pass_done, en_i && prod_i.valid && prod_i.rem == '0,
                    term_q.cur == $past(prod_i.cur) && term_q.rem == '0)

endmodule

>>> rtl/cwsh_out_stage.sv
// Output register: rounds the Q.30 term to Q.15 and saturates.
// Depends on cwsh_pkg.
`timescale 1ns / 1ps
`include "chebyshev_waveshaper_macros.svh"

module cwsh_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  cwsh_pkg::cwsh_term_t       term_i,
  output logic                       out_valid_o,
  output logic signed [cwsh_pkg::X_W-1:0] shaped_sample_o
);
  import cwsh_pkg::*;

  localparam int SUM_W = TERM_W + 1;
  localparam int Y_W   = SUM_W - 15;

  logic signed [SUM_W-1:0] sum;
  logic signed [Y_W-1:0]   y;
  logic signed [X_W-1:0]   shaped_d, shaped_q;
  logic                    valid_q;

  always_comb begin
    sum = SUM_W'($signed(term_i.cur)) + SUM_W'(64'sd16384);
    y   = sum[SUM_W-1:15];
    if (y > Y_W'(OUT_MAX)) begin
      shaped_d = OUT_MAX;
    end else if (y < Y_W'(OUT_MIN)) begin
      shaped_d = OUT_MIN;
    end else begin
      shaped_d = y[X_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= term_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      shaped_q <= shaped_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign shaped_sample_o = shaped_q;

  `CWSH_ASSERT_NEXT(a_sat_hi, en_i && term_i.valid && $signed(term_i.cur) >= SAT_HI_TERM,
                    shaped_sample_o == OUT_MAX)
  `CWSH_ASSERT_NEXT(a_sat_lo, en_i && term_i.valid && $signed(term_i.cur) <= -Q30_ONE,
                    shaped_sample_o == OUT_MIN)
  `CWSH_ASSERT_NEXT(a_valid_hold, !en_i, $stable(out_valid_o))

endmodule

>>> sim/chebyshev_waveshaper_tb.sv
// Self-checking testbench for chebyshev_waveshaper: random and directed Q1.15
// samples over many order settings, checked against an in-bench recurrence model.
// Depends on cwsh_pkg and the waveshaper RTL only.
`timescale 1ns / 1ps

module chebyshev_waveshaper_tb;

  import cwsh_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 2 * (MAX_ORDER - 1) + 10;
  localparam int STUCK_LIMIT  = 500;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 75;

  typedef struct {
    logic signed [X_W-1:0] sample;
    logic [CFG_W-1:0]      order;
    logic signed [X_W-1:0] shaped;
  } shaped_expect_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [X_W-1:0]  sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [X_W-1:0]  shaped_sample_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_poly_order_i = '0;

  logic signed [X_W-1:0]  sample_pending_q[$];
  shaped_expect_t         shaped_expect_q[$];
  logic [CFG_W-1:0]       order_shadow = ORDER_RESET;
  logic                   in_taken = 1'b0;
  bit                     calm = 1'b0;
  int                     in_gap = 0;
  int                     out_gap = 0;
  int                     stuck_cycles = 0;
  int                     error_count = 0;
  int                     samples_sent = 0;
  int                     results_checked = 0;
  int                     orders_used = 1;

  always #2 clk_i = ~clk_i;

  chebyshev_waveshaper i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .shaped_sample_o  (shaped_sample_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_poly_order_i (cfg_poly_order_i)
  );

  // T_n(x) by the three-term recurrence; terms are Q.30 clamped to +/-4.0
  function automatic logic signed [X_W-1:0] chebyshev_shape(logic [CFG_W-1:0] order,
                                                            logic signed [X_W-1:0] x);
    longint xs, prev_t, cur_t, twice, next_t, y;
    int     n;
    xs = longint'(x);
    n  = int'(order);
    if (n > MAX_ORDER) n = MAX_ORDER;
    prev_t = longint'(Q30_ONE);
    cur_t  = (n == 0) ? longint'(Q30_ONE) : xs * 32768;
    for (int k = 1; k < n; k++) begin
      twice  = (xs * cur_t + (64'sd1 <<< 13)) >>> 14;
      next_t = twice - prev_t;
      if (next_t > longint'(TERM_LIMIT)) next_t = longint'(TERM_LIMIT);
      if (next_t < -longint'(TERM_LIMIT)) next_t = -longint'(TERM_LIMIT);
      prev_t = cur_t;
      cur_t  = next_t;
    end
    y = (cur_t + (64'sd1 <<< 14)) >>> 15;
    if (y > longint'(OUT_MAX)) y = longint'(OUT_MAX);
    if (y < longint'(OUT_MIN)) y = longint'(OUT_MIN);
    return X_W'(y);
  endfunction

  // mostly uniform, with weight on full scale, near full scale and near zero
  function automatic logic signed [X_W-1:0] random_sample();
    logic signed [X_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = OUT_MAX;
          1:       v = OUT_MIN;
          2:       v = '0;
          default: v = -16'sd1;
        endcase
      end
      1, 2: begin
        if ($urandom_range(0, 1) != 0) v = OUT_MAX - X_W'($urandom_range(0, 2047));
        else v = OUT_MIN + X_W'($urandom_range(0, 2047));
      end
      3: v = X_W'($urandom_range(0, 511)) - 16'sd256;
      default: v = X_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic program_order(input logic [CFG_W-1:0] order);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_poly_order_i <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_shadow = order;
    orders_used++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_pending_q.size() > 0 || in_valid_i || shaped_expect_q.size() > 0)
      @(negedge clk_i);
  endtask

  // input driver: next sample only once the current transaction is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (sample_pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        sample_i   <= sample_pending_q.pop_front();
        if (!calm && $urandom_range(0, 6) == 0) in_gap <= $urandom_range(1, 10);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure in bursts
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_stall_i <= 1'b1;
      out_gap     <= out_gap - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 10);
    end
  end

  // monitor: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin
    shaped_expect_t ex;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        ex.sample = sample_i;
        ex.order  = order_shadow;
        ex.shaped = chebyshev_shape(order_shadow, sample_i);
        shaped_expect_q.push_back(ex);
        samples_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (shaped_expect_q.size() == 0) begin
          $display("%0t: unexpected shaped_sample %0d, nothing pending", $time,
                   shaped_sample_o);
          error_count++;
        end else begin
          ex = shaped_expect_q.pop_front();
          results_checked++;
          if (shaped_sample_o !== ex.shaped) begin
            $display("%0t: shaped_sample mismatch (sample %0d, order %0d): %s %0d, %s %0d",
                     $time, ex.sample, ex.order, "expected", ex.shaped, "actual",
                     shaped_sample_o);
            error_count++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("[chebyshev_waveshaper] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] order;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset order is 1: pass-through
    sample_pending_q.push_back('0);
    sample_pending_q.push_back(OUT_MAX);
    sample_pending_q.push_back(OUT_MIN);
    sample_pending_q.push_back(16'sd1);
    sample_pending_q.push_back(-16'sd1);
    sample_pending_q.push_back(16'sd16384);
    wait_drained();

    // order zero gives full scale for any sample
    program_order(CFG_W'(0));
    sample_pending_q.push_back('0);
    sample_pending_q.push_back(OUT_MAX);
    sample_pending_q.push_back(OUT_MIN);
    wait_drained();

    // T2(-1) = 1.0 saturates, T2(0) = -1.0
    program_order(CFG_W'(2));
    sample_pending_q.push_back(OUT_MIN);
    sample_pending_q.push_back('0);
    sample_pending_q.push_back(OUT_MAX);
    wait_drained();

    // orders above the maximum are capped
    program_order(CFG_W'(31));
    sample_pending_q.push_back(OUT_MIN);
    sample_pending_q.push_back(OUT_MAX);
    sample_pending_q.push_back('0);
    sample_pending_q.push_back(16'sd12345);
    wait_drained();

    program_order(CFG_W'(MAX_ORDER));
    sample_pending_q.push_back(OUT_MIN);
    sample_pending_q.push_back(OUT_MAX);
    sample_pending_q.push_back(-16'sd1);
    sample_pending_q.push_back(16'sd23170);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       order = CFG_W'(0);
        1:       order = CFG_W'(31);
        2:       order = CFG_W'(MAX_ORDER);
        3:       order = CFG_W'(MAX_ORDER + 1);
        4:       order = CFG_W'(1);
        5:       order = CFG_W'(2);
        6:       order = CFG_W'(3);
        7:       order = CFG_W'(8);
        8:       order = CFG_W'(MAX_ORDER - 1);
        default: order = CFG_W'($urandom_range(0, 31));
      endcase
      program_order(order);
      // last phase runs at full rate with no back-pressure
      if (p == RAND_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) sample_pending_q.push_back(random_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("chebyshev_waveshaper_tb: %0d samples sent over %0d order settings, %0d checked",
             samples_sent, orders_used, results_checked);
    $display("chebyshev_waveshaper_tb: orders in 0..31 incl. cap above %0d, %0d errors",
             MAX_ORDER, error_count);
    if (error_count == 0) begin
      $display("[chebyshev_waveshaper] OK");
    end else begin
      $display("[chebyshev_waveshaper] ERROR");
    end
    $finish;
  end

endmodule
